// ===== hdl/cstrip_pkg.sv =====
package cstrip_pkg;

    localparam logic [7:0] CH_SLASH     = 8'h2F;
    localparam logic [7:0] CH_STAR      = 8'h2A;
    localparam logic [7:0] CH_QUOTE     = 8'h22;
    localparam logic [7:0] CH_BACKSLASH = 8'h5C;
    localparam logic [7:0] CH_NEWLINE   = 8'h0A;

    // Number of fixed (non-buffered) bytes an item can produce, and its counter width
    localparam int unsigned FIXED_SLOTS = 3;
    localparam int unsigned FIXED_W     = 2;

    typedef struct packed {
        logic capture;     // item accepted, latch plan and update state
        logic rd;          // read one held whitespace byte
        logic load_flush;  // move RAM read data into the output register
        logic load_fixed;  // move next fixed byte into the output register
        logic commit;      // end of item, perform deferred buffer write
    } cmd_t;

    typedef struct packed {
        logic plan_flush;  // item being accepted flushes held whitespace
        logic plan_fixed;  // item being accepted has fixed bytes
        logic flush_last;  // current flush byte is the last one
        logic fixed_pend;  // latched item has fixed bytes
        logic fixed_last;  // current fixed byte is the last one
        logic out_free;    // output register can take a byte this cycle
    } status_t;

    function automatic logic is_ws(input logic [7:0] c);
        return (c == 8'h20) || ((c >= 8'h09) && (c <= 8'h0D));
    endfunction

endpackage

// ===== hdl/cstrip_ifs.sv =====
interface cstrip_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       end_of_text;

    modport source (output valid, output in_byte, output end_of_text, input ready);
    modport sink (input valid, input in_byte, input end_of_text, output ready);
endinterface

interface cstrip_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       last_of_run;

    modport source (output valid, output out_byte, output last_of_run, input ready);
    modport sink (input valid, input out_byte, input last_of_run, output ready);
endinterface

// ===== hdl/cstrip_ram.sv =====
module cstrip_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 32,
    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== hdl/cstrip_ctrl.sv =====
module cstrip_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  cstrip_pkg::status_t sts,
    output cstrip_pkg::cmd_t    cmd
);

    typedef enum logic [4:0] {
        S_IDLE      = 5'b00001,
        S_FLUSH_RD  = 5'b00010,
        S_FLUSH_OUT = 5'b00100,
        S_FIXED     = 5'b01000,
        S_COMMIT    = 5'b10000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    priority if (sts.plan_flush)
                        state_next = S_FLUSH_RD;
                    else if (sts.plan_fixed)
                        state_next = S_FIXED;
                    else
                        state_next = S_COMMIT;
                end
            end
            S_FLUSH_RD:
            begin
                cmd.rd     = 1'b1;
                state_next = S_FLUSH_OUT;
            end
            S_FLUSH_OUT:
            begin
                if (sts.out_free)
                begin
                    cmd.load_flush = 1'b1;
                    priority if (!sts.flush_last)
                        state_next = S_FLUSH_RD;
                    else if (sts.fixed_pend)
                        state_next = S_FIXED;
                    else
                        state_next = S_COMMIT;
                end
            end
            S_FIXED:
            begin
                if (sts.out_free)
                begin
                    cmd.load_fixed = 1'b1;
                    if (sts.fixed_last)
                    begin
                        state_next = S_COMMIT;
                    end
                end
            end
            S_COMMIT:
            begin
                cmd.commit = 1'b1;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

// ===== hdl/cstrip_dpath.sv =====
module cstrip_dpath #(
    parameter int unsigned WS_DEPTH = 32,
    localparam int unsigned CNT_W = $clog2(WS_DEPTH + 1),
    localparam int unsigned IDX_W = (WS_DEPTH > 1) ? $clog2(WS_DEPTH) : 1
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_wr_en,
    input  logic                cfg_wr_data,
    input  logic [7:0]          in_byte,
    input  logic                end_of_text,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [7:0]          out_byte,
    output logic                out_last,
    input  cstrip_pkg::cmd_t    cmd,
    output cstrip_pkg::status_t sts
);

    localparam int unsigned FW = cstrip_pkg::FIXED_W;

    // parser state
    logic strip_reg, strip_next;
    logic bc_reg, bc_next;
    logic so_reg, so_next;
    logic lc_reg, lc_next;
    logic sp_reg, sp_next;
    logic st_reg, st_next;
    logic [7:0] pb_reg, pb_next;
    logic pv_reg, pv_next;
    logic lne_reg, lne_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;

    // latched plan of the current item
    logic [CNT_W-1:0] flush_n_reg, flush_n_next;
    logic [CNT_W-1:0] flush_idx_reg, flush_idx_next;
    logic [7:0] fixed_reg [cstrip_pkg::FIXED_SLOTS];
    logic [7:0] fixed_next [cstrip_pkg::FIXED_SLOTS];
    logic [FW-1:0] fixed_n_reg, fixed_n_next;
    logic [FW-1:0] fixed_idx_reg, fixed_idx_next;
    logic wr_pend_reg, wr_pend_next;
    logic [IDX_W-1:0] wr_idx_reg, wr_idx_next;
    logic [7:0] wr_data_reg, wr_data_next;

    // output stage
    logic out_valid_reg, out_valid_next;
    logic [7:0] out_byte_reg, out_byte_next;
    logic out_last_reg, out_last_next;

    logic [7:0] ram_rdata;

    // plan for the item at the input
    logic [CNT_W-1:0] p_flush_n;
    logic [7:0] p_fixed [cstrip_pkg::FIXED_SLOTS];
    logic [FW-1:0] p_fixed_n;
    logic p_wr;
    logic [IDX_W-1:0] p_wr_idx;
    logic n_bc, n_so, n_lc, n_sp, n_st, n_pv, n_lne;
    logic [CNT_W-1:0] n_cnt;

    logic escaped, ws_c, is_close;
    logic slash_text, c_text, set_sp, c_push, c_buf, close_slash, any_push;
    logic lne_after, newline;
    logic [CNT_W-1:0] cnt_eff;

    always_comb
    begin
        escaped     = pv_reg && (pb_reg == cstrip_pkg::CH_BACKSLASH);
        ws_c        = cstrip_pkg::is_ws(in_byte);
        is_close    = (in_byte == cstrip_pkg::CH_NEWLINE) || end_of_text;
        slash_text  = 1'b0;
        c_text      = 1'b0;
        set_sp      = 1'b0;
        n_bc        = bc_reg;
        n_so        = so_reg;
        n_lc        = lc_reg;
        n_sp        = sp_reg;
        n_st        = st_reg;
        p_fixed     = '{default: 8'h00};
        p_fixed_n   = '0;

        priority if (lc_reg)
        begin
            // rest of line is dropped
        end
        else if (bc_reg)
        begin
            if (st_reg && (in_byte == cstrip_pkg::CH_SLASH))
            begin
                n_bc = 1'b0;
                n_st = 1'b0;
            end
            else
            begin
                n_st = (in_byte == cstrip_pkg::CH_STAR);
            end
        end
        else
        begin
            if (sp_reg)
            begin
                n_sp = 1'b0;
                priority if (in_byte == cstrip_pkg::CH_STAR)
                begin
                    n_bc = 1'b1;
                    n_st = 1'b0;
                end
                else if (in_byte == cstrip_pkg::CH_SLASH)
                begin
                    n_lc = 1'b1;
                end
                else
                begin
                    slash_text = 1'b1;
                end
            end
            // plain byte handling
            if (!sp_reg || slash_text)
            begin
                priority if ((in_byte == cstrip_pkg::CH_QUOTE) && !escaped)
                begin
                    n_so   = !so_reg;
                    c_text = 1'b1;
                end
                else if (so_reg)
                begin
                    c_text = 1'b1;
                end
                else if (in_byte == cstrip_pkg::CH_SLASH)
                begin
                    n_sp   = 1'b1;
                    set_sp = 1'b1;
                end
                else
                begin
                    c_text = 1'b1;
                end
            end
        end

        c_push      = c_text && !ws_c;
        c_buf       = c_text && ws_c;
        close_slash = is_close && n_sp;
        any_push    = slash_text || c_push || close_slash;
        lne_after   = lne_reg || any_push;
        newline     = is_close && lne_after;

        // a held slash on a full buffer drops the newest held whitespace
        cnt_eff = (set_sp && (cnt_reg == CNT_W'(WS_DEPTH))) ? CNT_W'(WS_DEPTH - 1) : cnt_reg;
        p_flush_n = any_push ? cnt_eff : '0;

        if (slash_text)
        begin
            p_fixed[p_fixed_n] = cstrip_pkg::CH_SLASH;
            p_fixed_n = p_fixed_n + FW'(1);
        end
        if (c_push)
        begin
            p_fixed[p_fixed_n] = in_byte;
            p_fixed_n = p_fixed_n + FW'(1);
        end
        if (close_slash)
        begin
            p_fixed[p_fixed_n] = cstrip_pkg::CH_SLASH;
            p_fixed_n = p_fixed_n + FW'(1);
        end
        if (newline)
        begin
            p_fixed[p_fixed_n] = cstrip_pkg::CH_NEWLINE;
            p_fixed_n = p_fixed_n + FW'(1);
        end

        // whitespace lands after any flush, so the write is deferred to commit
        p_wr     = c_buf && !is_close && (any_push || (cnt_reg < CNT_W'(WS_DEPTH)));
        p_wr_idx = any_push ? '0 : cnt_reg[IDX_W-1:0];

        priority if (is_close)
            n_cnt = '0;
        else if (any_push)
            n_cnt = c_buf ? CNT_W'(1) : '0;
        else if (c_buf && (cnt_reg < CNT_W'(WS_DEPTH)))
            n_cnt = cnt_reg + CNT_W'(1);
        else
            n_cnt = cnt_eff;

        n_pv  = !is_close;
        n_lne = is_close ? 1'b0 : lne_after;
        if (is_close)
        begin
            n_sp = 1'b0;
            n_so = 1'b0;
            n_lc = 1'b0;
            n_st = 1'b0;
        end
        if (end_of_text)
        begin
            n_bc = 1'b0;
            n_st = 1'b0;
        end

        // echo mode
        if (!strip_reg)
        begin
            p_flush_n  = '0;
            p_fixed    = '{default: 8'h00};
            p_fixed[0] = in_byte;
            p_fixed_n  = FW'(1);
            p_wr       = 1'b0;
        end
    end

    always_comb
    begin
        strip_next     = cfg_wr_en ? cfg_wr_data : strip_reg;
        bc_next        = bc_reg;
        so_next        = so_reg;
        lc_next        = lc_reg;
        sp_next        = sp_reg;
        st_next        = st_reg;
        pb_next        = pb_reg;
        pv_next        = pv_reg;
        lne_next       = lne_reg;
        cnt_next       = cnt_reg;
        flush_n_next   = flush_n_reg;
        flush_idx_next = flush_idx_reg;
        fixed_next     = fixed_reg;
        fixed_n_next   = fixed_n_reg;
        fixed_idx_next = fixed_idx_reg;
        wr_pend_next   = wr_pend_reg;
        wr_idx_next    = wr_idx_reg;
        wr_data_next   = wr_data_reg;
        out_valid_next = out_valid_reg && !out_ready;
        out_byte_next  = out_byte_reg;
        out_last_next  = out_last_reg;

        if (cmd.capture)
        begin
            flush_n_next   = p_flush_n;
            flush_idx_next = '0;
            fixed_next     = p_fixed;
            fixed_n_next   = p_fixed_n;
            fixed_idx_next = '0;
            wr_pend_next   = p_wr;
            wr_idx_next    = p_wr_idx;
            wr_data_next   = in_byte;
            if (strip_reg)
            begin
                bc_next  = n_bc;
                so_next  = n_so;
                lc_next  = n_lc;
                sp_next  = n_sp;
                st_next  = n_st;
                pb_next  = in_byte;
                pv_next  = n_pv;
                lne_next = n_lne;
                cnt_next = n_cnt;
            end
        end

        if (cmd.load_flush)
        begin
            out_valid_next = 1'b1;
            out_byte_next  = ram_rdata;
            out_last_next  = sts.flush_last && !sts.fixed_pend;
            flush_idx_next = flush_idx_reg + CNT_W'(1);
        end

        if (cmd.load_fixed)
        begin
            out_valid_next = 1'b1;
            out_byte_next  = fixed_reg[fixed_idx_reg];
            out_last_next  = sts.fixed_last;
            fixed_idx_next = fixed_idx_reg + FW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            strip_reg     <= 1'b0;
            bc_reg        <= 1'b0;
            so_reg        <= 1'b0;
            lc_reg        <= 1'b0;
            sp_reg        <= 1'b0;
            st_reg        <= 1'b0;
            pb_reg        <= 8'h00;
            pv_reg        <= 1'b0;
            lne_reg       <= 1'b0;
            cnt_reg       <= '0;
            flush_n_reg   <= '0;
            flush_idx_reg <= '0;
            fixed_n_reg   <= '0;
            fixed_idx_reg <= '0;
            wr_pend_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            strip_reg     <= strip_next;
            bc_reg        <= bc_next;
            so_reg        <= so_next;
            lc_reg        <= lc_next;
            sp_reg        <= sp_next;
            st_reg        <= st_next;
            pb_reg        <= pb_next;
            pv_reg        <= pv_next;
            lne_reg       <= lne_next;
            cnt_reg       <= cnt_next;
            flush_n_reg   <= flush_n_next;
            flush_idx_reg <= flush_idx_next;
            fixed_n_reg   <= fixed_n_next;
            fixed_idx_reg <= fixed_idx_next;
            wr_pend_reg   <= wr_pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        fixed_reg    <= fixed_next;
        wr_idx_reg   <= wr_idx_next;
        wr_data_reg  <= wr_data_next;
        out_byte_reg <= out_byte_next;
        out_last_reg <= out_last_next;
    end

    cstrip_ram #(
        .WIDTH (8),
        .DEPTH (WS_DEPTH)
    ) u_space_ram (
        .clk   (clk),
        .we    (cmd.commit && wr_pend_reg),
        .waddr (wr_idx_reg),
        .wdata (wr_data_reg),
        .re    (cmd.rd),
        .raddr (flush_idx_reg[IDX_W-1:0]),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        sts.plan_flush = (p_flush_n != '0);
        sts.plan_fixed = (p_fixed_n != '0);
        sts.flush_last = ((flush_idx_reg + CNT_W'(1)) == flush_n_reg);
        sts.fixed_pend = (fixed_n_reg != '0);
        sts.fixed_last = ((fixed_idx_reg + FW'(1)) == fixed_n_reg);
        sts.out_free   = !out_valid_reg || out_ready;
    end

    assign out_valid = out_valid_reg;
    assign out_byte  = out_byte_reg;
    assign out_last  = out_last_reg;

endmodule

// ===== hdl/c_comment_stripper.sv =====
// Channel   Dir  Payload                    Handshake
// in_ch     in   in_byte[7:0], end_of_text  valid/ready
// out_ch    out  out_byte[7:0], last_of_run valid/ready
// cfg       in   cfg_wr_data (strip_enable) cfg_wr_en, no wait
//
// An item is accepted, then committed; each flushed whitespace byte is read from
// the space RAM and then loaded, each other emitted byte is loaded directly; the
// registered read of the whitespace RAM, issued one byte at a time, sets the flush rate.
// Asynchronous active-low reset clears all parser state; the whitespace RAM is
// not cleared, only entries below the held count are read.
// A stalled output holds its byte; the next item is taken while it waits.
module c_comment_stripper #(
    parameter int unsigned WS_DEPTH = 32
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_wr_en,
    input  logic                cfg_wr_data,
    cstrip_in_if.sink           in_ch,
    cstrip_out_if.source        out_ch
);

    cstrip_pkg::cmd_t    cmd;
    cstrip_pkg::status_t sts;

    cstrip_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_ch.valid),
        .in_ready (in_ch.ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    cstrip_dpath #(
        .WS_DEPTH (WS_DEPTH)
    ) u_dpath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_byte     (in_ch.in_byte),
        .end_of_text (in_ch.end_of_text),
        .out_valid   (out_ch.valid),
        .out_ready   (out_ch.ready),
        .out_byte    (out_ch.out_byte),
        .out_last    (out_ch.last_of_run),
        .cmd         (cmd),
        .sts         (sts)
    );

`ifndef SYNTHESIS
    // a byte is only loaded into a free output register
    a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.load_flush || cmd.load_fixed) |-> (!out_ch.valid || out_ch.ready))
        else $error("output register overwritten");

    // RAM data is consumed exactly when the output frees up after a read
    a_read_use: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.rd |=> (cmd.load_flush == (!out_ch.valid || out_ch.ready)))
        else $error("flush read not followed by load");

    // commit ends the item and reopens the input
    a_commit_ready: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |=> in_ch.ready)
        else $error("input not ready after commit");

    // capture happens only on an accepted item
    a_capture: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.capture |-> (in_ch.valid && in_ch.ready))
        else $error("capture without accepted item");
`endif

endmodule
